[src/dmpid_pkg.sv]
// Package with shared widths, constants and register indexes of the dual-mode PID controller.
`default_nettype none

package dmpid_pkg;

    localparam int ERR_W = 17;
    localparam int DE_W = 18;
    localparam int DD_W = 19;
    localparam int MULT_W = 17;
    localparam int CNT_W = 5;
    localparam int MIX_W = 52;
    localparam int FD_W = 35;
    localparam int ALPHA_SHIFT = 16;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_INDEX_W = 3;

    localparam logic [MULT_W-1:0] ALPHA_ONE = 17'h10000;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KP_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KI_GAIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KD_GAIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_ALPHA = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN = 3'd7;

    localparam logic MODE_POSITIONAL = 1'b0;

endpackage

`default_nettype wire

[src/dual_mode_pid_controller.sv]
// Top level of the dual-mode PID controller with a bit-serial multiply-accumulate sequencer.
`default_nettype none

// Each transaction on the input channel carries a setpoint and a measurement and yields one
// drive value. All products go through a single shift-and-add multiplier that consumes one
// multiplier bit per cycle. In positional mode five multiplies are needed and in incremental
// mode three; the next transaction is accepted only once the sequencer is back in idle.
// A finished result waits in an output register while the next transaction is accepted;
// only a second result that cannot be handed over holds the sequencer.
module dual_mode_pid_controller
    import dmpid_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [15:0]      target,
    input  wire logic signed [15:0]      measured,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [15:0]           drive
);

    localparam int OA_W = 16 + FRACTION_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_P_INT,
        S_P_ICLAMP,
        S_P_DPROD,
        S_P_DMIX1,
        S_P_DMIX2,
        S_P_DSTORE,
        S_I_START,
        S_I_SECOND,
        S_I_THIRD,
        S_OCLAMP
    } state_t;

    logic                     mode_reg;
    logic [15:0]              kp_reg;
    logic [15:0]              ki_reg;
    logic [15:0]              kd_reg;
    logic [MULT_W-1:0]        alpha_reg;
    logic [14:0]              ilim_reg;
    logic signed [15:0]       out_max_reg;
    logic signed [15:0]       out_min_reg;

    state_t                   state_reg;
    state_t                   ret_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [MULT_W-1:0]        mult_reg;
    logic signed [MIX_W-1:0]  mcand_reg;
    logic signed [MIX_W-1:0]  acc_reg;

    logic signed [ERR_W-1:0]  e0_reg;
    logic signed [ERR_W-1:0]  e1_reg;
    logic signed [ERR_W-1:0]  e2_reg;
    logic signed [DE_W-1:0]   de_reg;
    logic signed [DD_W-1:0]   dd_reg;
    logic signed [OA_W-1:0]   integ_reg;
    logic signed [FD_W-1:0]   fd_reg;
    logic signed [OA_W-1:0]   oa_reg;
    logic                     out_valid_reg;
    logic signed [15:0]       drive_reg;

    logic signed [ERR_W-1:0]  e0_calc;
    logic [MULT_W-1:0]        alpha_sat;
    logic [MULT_W-1:0]        alpha_inv;
    logic signed [MIX_W-1:0]  lim_pos;
    logic signed [MIX_W-1:0]  lim_neg;
    logic signed [MIX_W-1:0]  integ_hi;
    logic signed [MIX_W-1:0]  integ_clamp;
    logic signed [MIX_W-1:0]  out_hi;
    logic signed [MIX_W-1:0]  out_lo;
    logic signed [MIX_W-1:0]  out_step;
    logic signed [MIX_W-1:0]  out_clamp;
    logic signed [MIX_W-1:0]  acc_mac;

    assign e0_calc = ERR_W'(target) - ERR_W'(measured);
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_inv = ALPHA_ONE - alpha_sat;

    assign lim_pos = MIX_W'(signed'({1'b0, ilim_reg})) <<< FRACTION_BITS;
    assign lim_neg = -lim_pos;
    assign integ_hi = (acc_reg >= lim_pos) ? lim_pos : acc_reg;
    assign integ_clamp = (integ_hi <= lim_neg) ? lim_neg : integ_hi;

    assign out_hi = MIX_W'(out_max_reg) <<< FRACTION_BITS;
    assign out_lo = MIX_W'(out_min_reg) <<< FRACTION_BITS;
    assign out_step = (acc_reg >= out_hi) ? out_hi : acc_reg;
    assign out_clamp = (out_step <= out_lo) ? out_lo : out_step;

    assign acc_mac = mult_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_POSITIONAL;
            kp_reg <= 16'd1280;
            ki_reg <= 16'd512;
            kd_reg <= 16'd0;
            alpha_reg <= '0;
            ilim_reg <= 15'd1500;
            out_max_reg <= 16'sd2000;
            out_min_reg <= -16'sd2000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:           mode_reg <= cfg_data[0];
                REG_KP_GAIN:        kp_reg <= cfg_data[15:0];
                REG_KI_GAIN:        ki_reg <= cfg_data[15:0];
                REG_KD_GAIN:        kd_reg <= cfg_data[15:0];
                REG_DERIV_ALPHA:    alpha_reg <= cfg_data;
                REG_INTEGRAL_LIMIT: ilim_reg <= cfg_data[14:0];
                REG_OUT_MAX:        out_max_reg <= signed'(cfg_data[15:0]);
                REG_OUT_MIN:        out_min_reg <= signed'(cfg_data[15:0]);
                default:            mode_reg <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            cnt_reg <= '0;
            mult_reg <= '0;
            mcand_reg <= '0;
            acc_reg <= '0;
            out_valid_reg <= 1'b0;
            e0_reg <= '0;
            e1_reg <= '0;
            e2_reg <= '0;
            de_reg <= '0;
            dd_reg <= '0;
            integ_reg <= '0;
            fd_reg <= '0;
            oa_reg <= '0;
            drive_reg <= '0;
        end
        else
        begin
            if (state_reg == S_OCLAMP && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        e0_reg <= e0_calc;
                        de_reg <= DE_W'(e0_calc) - DE_W'(e1_reg);
                        dd_reg <= DD_W'(e0_calc) - (DD_W'(e1_reg) <<< 1) + DD_W'(e2_reg);
                        e1_reg <= e0_calc;
                        e2_reg <= e1_reg;
                        state_reg <= (mode_reg == MODE_POSITIONAL) ? S_P_INT : S_I_START;
                    end
                end
                S_MAC:
                begin
                    acc_reg <= acc_mac;
                    mcand_reg <= mcand_reg <<< 1;
                    mult_reg <= mult_reg >> 1;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_P_INT:
                begin
                    acc_reg <= MIX_W'(integ_reg);
                    mult_reg <= MULT_W'(ki_reg);
                    mcand_reg <= MIX_W'(e0_reg);
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_P_ICLAMP;
                    state_reg <= S_MAC;
                end
                S_P_ICLAMP:
                begin
                    integ_reg <= integ_clamp[OA_W-1:0];
                    state_reg <= S_P_DPROD;
                end
                S_P_DPROD:
                begin
                    acc_reg <= '0;
                    mult_reg <= MULT_W'(kd_reg);
                    mcand_reg <= MIX_W'(de_reg);
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_P_DMIX1;
                    state_reg <= S_MAC;
                end
                S_P_DMIX1:
                begin
                    acc_reg <= '0;
                    mult_reg <= alpha_inv;
                    mcand_reg <= acc_reg;
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_P_DMIX2;
                    state_reg <= S_MAC;
                end
                S_P_DMIX2:
                begin
                    mult_reg <= alpha_sat;
                    mcand_reg <= MIX_W'(fd_reg);
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_P_DSTORE;
                    state_reg <= S_MAC;
                end
                S_P_DSTORE:
                begin
                    fd_reg <= acc_reg[ALPHA_SHIFT +: FD_W];
                    acc_reg <= MIX_W'(integ_reg)
                        + MIX_W'(signed'(acc_reg[ALPHA_SHIFT +: FD_W]));
                    mult_reg <= MULT_W'(kp_reg);
                    mcand_reg <= MIX_W'(e0_reg);
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_OCLAMP;
                    state_reg <= S_MAC;
                end
                S_I_START:
                begin
                    acc_reg <= MIX_W'(oa_reg);
                    mult_reg <= MULT_W'(kp_reg);
                    mcand_reg <= MIX_W'(de_reg);
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_I_SECOND;
                    state_reg <= S_MAC;
                end
                S_I_SECOND:
                begin
                    mult_reg <= MULT_W'(ki_reg);
                    mcand_reg <= MIX_W'(e0_reg);
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_I_THIRD;
                    state_reg <= S_MAC;
                end
                S_I_THIRD:
                begin
                    mult_reg <= MULT_W'(kd_reg);
                    mcand_reg <= MIX_W'(dd_reg);
                    cnt_reg <= CNT_W'(MULT_W - 1);
                    ret_reg <= S_OCLAMP;
                    state_reg <= S_MAC;
                end
                S_OCLAMP:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        oa_reg <= out_clamp[OA_W-1:0];
                        drive_reg <= out_clamp[FRACTION_BITS +: 16];
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A new result appears only when the output clamp step completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OCLAMP)
    else $error("result raised outside the output clamp step");

    // The incremental mode never touches the integral or the filtered derivative.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && mode_reg != MODE_POSITIONAL) |=>
            ($stable(integ_reg) && $stable(fd_reg)))
    else $error("positional state changed during an incremental transaction");

    // The multiplier always hands control back after its last bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC && cnt_reg == '0) |=> (state_reg != S_MAC && state_reg != S_IDLE))
    else $error("multiplier did not return to its caller");

endmodule

`default_nettype wire
